// File: src/positional_list_buffer_top_assert.svh
// assertion macros used by the checker file
`ifndef POSITIONAL_LIST_BUFFER_TOP_ASSERT_SVH
`define POSITIONAL_LIST_BUFFER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define PLB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define PLB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/plb_pkg.sv
package plb_pkg;

    // list geometry
    localparam int unsigned CAPACITY   = 16;
    localparam int unsigned DATA_WIDTH = 32;
    localparam int unsigned IDX_W      = $clog2(CAPACITY);
    localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);
    localparam int unsigned POS_W      = 5;
    localparam int unsigned CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

    // request codes
    typedef enum logic [2:0] {
        REQ_ADD_FRONT = 3'd0,
        REQ_ADD_REAR  = 3'd1,
        REQ_REM_FRONT = 3'd2,
        REQ_REM_REAR  = 3'd3,
        REQ_INS_AT    = 3'd4,
        REQ_REM_AT    = 3'd5
    } t_req;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // operation broadcast to the cell row
    typedef enum logic [1:0] {
        CMD_HOLD = 2'd0,
        CMD_INS  = 2'd1,
        CMD_DEL  = 2'd2
    } t_op;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [POS_W-1:0]   position;
        logic signed [31:0] new_value;
    } t_in_beat;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] removed_value;
        logic [4:0]         entry_total;
    } t_out_beat;

    typedef struct packed {
        t_op                   op;
        logic [IDX_W-1:0]      pos;
        logic [DATA_WIDTH-1:0] data;
    } t_cell_cmd;

    typedef struct packed {
        t_status          status;
        logic             is_del;
        logic [CNT_W-1:0] total;
    } t_ctrl_res;

    // sign-extend a stored entry to the 32-bit result field
    function automatic logic signed [31:0] f_sext(input logic [DATA_WIDTH-1:0] v);
        logic signed [31:0] r;
        r = 32'(signed'(v));
        return r;
    endfunction

endpackage

// File: src/positional_list_buffer_top.sv
// Positional list buffer: ordered list of up to CAPACITY signed entries.
// Input channel (i_in_valid / o_in_stall / i_in_beat) carries one request per
// beat: add front or rear, remove front or rear, insert before a position, or
// remove at a position. Output channel (o_out_valid / i_out_stall /
// o_out_beat) returns one result beat per request with status, removed value
// and entry count after the request.
// Entries sit in a row of cells; each accepted request broadcasts one
// command and every cell loads itself, its left or its right neighbor in the
// same cycle, for a request of any kind.
// Latency: the result is valid the cycle after the request is accepted.
// Throughput: one request per cycle while the output is not stalled.
// Reset clears the entry count and the output valid; entry contents are not
// cleared and are only read once written.
// When the receiver stalls a valid result, the result holds and o_in_stall
// rises, so no further request is taken until the result is drained.
module positional_list_buffer_top
    import plb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    logic                  w_accept;
    t_cell_cmd             w_cmd;
    t_ctrl_res             w_res;
    logic [DATA_WIDTH-1:0] w_data [CAPACITY];
    logic [DATA_WIDTH-1:0] w_tap  [CAPACITY+1];
    logic                  r_out_valid;
    t_out_beat             r_out;
    t_out_beat             n_out;

    // handshake
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    plb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_beat   (i_in_beat),
        .o_cmd    (w_cmd),
        .o_res    (w_res)
    );

    // cell row with read tap chain
    assign w_tap[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_cmd.data;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        plb_cell u_cell (
            .i_clk        (i_clk),
            .i_index      (IDX_W'(g)),
            .i_cmd        (w_cmd),
            .i_left_data  (w_left),
            .i_right_data (w_right),
            .i_tap        (w_tap[g]),
            .o_data       (w_data[g]),
            .o_tap        (w_tap[g+1])
        );
    end

    // result beat
    always_comb begin
        n_out.status        = w_res.status;
        n_out.removed_value = (w_res.is_del && w_res.status == ST_DONE)
                              ? f_sext(w_tap[CAPACITY]) : '0;
        n_out.entry_total   = 5'(w_res.total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

// File: src/plb_cell.sv
module plb_cell
    import plb_pkg::*;
(
    input  logic                  i_clk,
    input  logic [IDX_W-1:0]      i_index,
    input  t_cell_cmd             i_cmd,
    input  logic [DATA_WIDTH-1:0] i_left_data,
    input  logic [DATA_WIDTH-1:0] i_right_data,
    input  logic [DATA_WIDTH-1:0] i_tap,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [DATA_WIDTH-1:0] o_tap
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  w_hit;
    logic                  w_above;

    assign w_hit   = (i_index == i_cmd.pos);
    assign w_above = (i_index > i_cmd.pos);

    // insert: load at target, take left neighbor above it; delete: take right neighbor
    always_comb begin
        n_data = r_data;
        unique case (i_cmd.op)
            CMD_INS: begin
                if (w_hit) begin
                    n_data = i_cmd.data;
                end else if (w_above) begin
                    n_data = i_left_data;
                end
            end
            CMD_DEL: begin
                if (w_hit || w_above) begin
                    n_data = i_right_data;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // read tap: the addressed cell contributes its entry to the passing chain
    assign o_tap  = i_tap | (w_hit ? r_data : '0);
    assign o_data = r_data;

endmodule

// File: src/plb_ctrl.sv
module plb_ctrl
    import plb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_beat  i_beat,
    output t_cell_cmd o_cmd,
    output t_ctrl_res o_res
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_full;
    logic             w_empty;
    logic [CMP_W-1:0] w_pos_ext;
    logic [CMP_W-1:0] w_cnt_ext;
    t_op              w_op;
    logic [IDX_W-1:0] w_pos;
    t_status          w_status;

    assign w_full    = (r_count == CNT_W'(CAPACITY));
    assign w_empty   = (r_count == '0);
    assign w_pos_ext = CMP_W'(i_beat.position);
    assign w_cnt_ext = CMP_W'(r_count);

    // decode request against current fill level
    always_comb begin
        w_op     = CMD_HOLD;
        w_pos    = '0;
        w_status = ST_DONE;
        unique case (t_req'(i_beat.req_type))
            REQ_ADD_FRONT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_op = CMD_INS;
                end
            end
            REQ_ADD_REAR: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_op  = CMD_INS;
                    w_pos = IDX_W'(r_count);
                end
            end
            REQ_REM_FRONT: begin
                if (w_empty) begin
                    w_status = ST_RANGE;
                end else begin
                    w_op = CMD_DEL;
                end
            end
            REQ_REM_REAR: begin
                if (w_empty) begin
                    w_status = ST_RANGE;
                end else begin
                    w_op  = CMD_DEL;
                    w_pos = IDX_W'(r_count - CNT_W'(1));
                end
            end
            REQ_INS_AT: begin
                if (w_pos_ext > w_cnt_ext) begin
                    w_status = ST_RANGE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_op  = CMD_INS;
                    w_pos = IDX_W'(i_beat.position);
                end
            end
            REQ_REM_AT: begin
                if (w_pos_ext >= w_cnt_ext) begin
                    w_status = ST_RANGE;
                end else begin
                    w_op  = CMD_DEL;
                    w_pos = IDX_W'(i_beat.position);
                end
            end
            default: begin
                w_status = ST_RANGE;
            end
        endcase
    end

    // count after the request
    always_comb begin
        n_count = r_count;
        unique case (w_op)
            CMD_INS:  n_count = r_count + CNT_W'(1);
            CMD_DEL:  n_count = r_count - CNT_W'(1);
            default:  n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

    // cells move only on an accepted beat
    assign o_cmd.op   = i_accept ? w_op : CMD_HOLD;
    assign o_cmd.pos  = w_pos;
    assign o_cmd.data = DATA_WIDTH'($unsigned(i_beat.new_value));

    assign o_res.status = w_status;
    assign o_res.is_del = (w_op == CMD_DEL);
    assign o_res.total  = n_count;

endmodule

// File: src/plb_checker.sv
`include "positional_list_buffer_top_assert.svh"

module plb_checker
    import plb_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_beat
);

    // stalled result beat holds
    `PLB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_beat), "stalled result changed")

    // every accepted request yields a result the next cycle
    `PLB_ASSERT_NEXT(a_one_result, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_out_valid, "accepted request gave no result")

    // count never exceeds capacity
    `PLB_ASSERT_NOW(a_total_cap, i_clk, i_rst_n, o_out_valid, o_out_beat.entry_total <= 5'(CAPACITY), "entry count beyond capacity")

    // failed requests report no removed value
    `PLB_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_out_valid && o_out_beat.status != ST_DONE, o_out_beat.removed_value == '0, "failed request reports a value")

    // full status only when the list is full
    `PLB_ASSERT_NOW(a_full_cnt, i_clk, i_rst_n, o_out_valid && o_out_beat.status == ST_FULL, o_out_beat.entry_total == 5'(CAPACITY), "full status on a list with room")

endmodule

bind positional_list_buffer_top plb_checker u_plb_checker (.*);
